FILE: hdl/nnis_pkg.sv
// Shared types and constants for the nearest-neighbour image scaler.
// Field widths, register indexes, controller states and parameter defaults.
// No dependencies.
package nnis_pkg;

    localparam int COORD_W    = 6;
    localparam int CFG_W      = 7;
    localparam int CFG_ADDR_W = 2;
    localparam int PIX_OUT_W  = 8;

    localparam int S_TDATA_W  = 24;
    localparam int M_TDATA_W  = 24;
    localparam int M_PAD_W    = M_TDATA_W - PIX_OUT_W - 2 * COORD_W;

    localparam int DEF_MAX_ROWS   = 64;
    localparam int DEF_MAX_COLS   = 64;
    localparam int DEF_PIXEL_BITS = 8;

    localparam logic [CFG_W-1:0] CFG_RESET = 7'd64;

    typedef enum logic [CFG_ADDR_W-1:0] {
        REG_SRC_ROWS = 2'd0,
        REG_SRC_COLS = 2'd1,
        REG_DST_ROWS = 2'd2,
        REG_DST_COLS = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        ST_IDLE = 2'd0,
        ST_MAP  = 2'd1,
        ST_DONE = 2'd2
    } nnis_state_t;

endpackage

FILE: hdl/nnis_ram.sv
// Generic single-clock RAM with one write port and one registered read port.
// Used for the frame store. No dependencies.
module nnis_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4096
) (
    input  logic                     aclk,
    input  logic                     wr_en,
    input  logic [$clog2(DEPTH)-1:0] wr_addr,
    input  logic [WIDTH-1:0]         wr_data,
    input  logic                     rd_en,
    input  logic [$clog2(DEPTH)-1:0] rd_addr,
    output logic [WIDTH-1:0]         rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

FILE: hdl/nnis_map.sv
// Coordinate mapper: computes min(round(out*src/dst), src-1) with a multiply stage
// followed by a bit-serial restoring divider. Depends on nnis_pkg.
module nnis_map import nnis_pkg::*; (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic [COORD_W-1:0] coord,
    input  logic [CFG_W-1:0]   src_size,
    input  logic [CFG_W-1:0]   dst_size,
    output logic               done,
    output logic [CFG_W-1:0]   src_used
);

    localparam int PROD_W = COORD_W + CFG_W;
    localparam int NUM_W  = PROD_W + 1;
    localparam int DEN_W  = CFG_W + 1;
    localparam int QBITS  = CFG_W;
    localparam int CNT_W  = $clog2(QBITS + 1);

    logic [PROD_W-1:0] prod_reg;
    logic [CFG_W-1:0]  src_reg;
    logic [DEN_W-1:0]  den_reg;
    logic [DEN_W-1:0]  rem_reg;
    logic [QBITS-1:0]  low_reg;
    logic [QBITS-1:0]  q_reg;
    logic [CNT_W-1:0]  cnt_reg;
    logic              busy_reg;
    logic              init_reg;

    logic [NUM_W-1:0]  num;
    logic [DEN_W:0]    trial;
    logic              fits;

    assign num   = {prod_reg, 1'b0} + NUM_W'(den_reg[DEN_W-1:1]);
    assign trial = {rem_reg, low_reg[QBITS-1]};
    assign fits  = trial >= {1'b0, den_reg};

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            init_reg <= 1'b0;
            cnt_reg  <= '0;
        end else if (start) begin
            busy_reg <= 1'b1;
            init_reg <= 1'b1;
            cnt_reg  <= CNT_W'(QBITS);
        end else if (init_reg) begin
            init_reg <= 1'b0;
        end else if (busy_reg && cnt_reg != '0) begin
            cnt_reg <= cnt_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            prod_reg <= PROD_W'(coord * src_size);
            src_reg  <= src_size;
            den_reg  <= {dst_size, 1'b0};
        end else if (init_reg) begin
            rem_reg <= DEN_W'(num[NUM_W-1:QBITS]);
            low_reg <= num[QBITS-1:0];
            q_reg   <= '0;
        end else if (busy_reg && cnt_reg != '0) begin
            if (fits) begin
                rem_reg <= DEN_W'(trial - {1'b0, den_reg});
            end else begin
                rem_reg <= trial[DEN_W-1:0];
            end
            q_reg   <= {q_reg[QBITS-2:0], fits};
            low_reg <= {low_reg[QBITS-2:0], 1'b0};
        end
    end

    assign done     = busy_reg && !init_reg && cnt_reg == '0;
    assign src_used = (q_reg >= src_reg) ? src_reg - 1'b1 : q_reg;

endmodule

FILE: hdl/nearest_neighbor_image_scaler_core.sv
// Nearest-neighbour image scaler: frame store, two coordinate mappers and the controller.
// Depends on nnis_pkg, nnis_ram and nnis_map.
//
// A load request (tuser 0) writes one pixel into the frame store and leaves the block ready.
// A query request (tuser 1) inside the output size passes through these steps: the
// product is formed at acceptance, then a set-up step, seven quotient bits of the
// bit-serial divider (rows and columns are mapped in parallel), one frame-store read
// and the output register. The next request is taken after the result is loaded into
// the output register. A query outside the output size goes from acceptance straight
// to the output register. One request is in flight at a time; a finished result waits
// in the output register while the next request is taken, and a stalled output holds
// back the next query result and, until that result is loaded, any further request.
// Loaded pixels must precede any query that selects them.
module nearest_neighbor_image_scaler_core import nnis_pkg::*; #(
    parameter int MAX_ROWS   = DEF_MAX_ROWS,
    parameter int MAX_COLS   = DEF_MAX_COLS,
    parameter int PIXEL_BITS = DEF_PIXEL_BITS
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  cfg_we,
    input  logic [CFG_ADDR_W-1:0] cfg_addr,
    input  logic [CFG_W-1:0]      cfg_wdata,
    input  logic                  s_axis_tvalid,
    output logic                  s_axis_tready,
    // row [5:0], col [11:6], pixel_in [19:12], zero [23:20]
    input  logic [S_TDATA_W-1:0]  s_axis_tdata,
    // mode [0]
    input  logic                  s_axis_tuser,
    output logic                  m_axis_tvalid,
    input  logic                  m_axis_tready,
    // pixel_out [7:0], src_row_used [13:8], src_col_used [19:14], zero [23:20]
    output logic [M_TDATA_W-1:0]  m_axis_tdata,
    // out_of_range [0]
    output logic                  m_axis_tuser
);

    localparam int DEPTH  = MAX_ROWS * MAX_COLS;
    localparam int ADDR_W = $clog2(DEPTH);

    logic [CFG_W-1:0] src_rows_reg, src_cols_reg, dst_rows_reg, dst_cols_reg;
    nnis_state_t      state_reg, state_next;

    logic [COORD_W-1:0]    in_row, in_col;
    logic [PIX_OUT_W-1:0]  in_pix;
    logic                  accept, is_query, in_oor, in_store;
    logic [CFG_W-1:0]      eff_rows, eff_cols, srow, scol;
    logic                  row_done, col_done, map_start, rd_en, out_load;
    logic [ADDR_W-1:0]     wr_addr, rd_addr;
    logic [PIXEL_BITS-1:0] rd_data;
    logic                  oor_reg;

    logic                 m_valid_reg, m_oor_reg;
    logic [PIX_OUT_W-1:0] m_pix_reg;
    logic [COORD_W-1:0]   m_row_reg, m_col_reg;

    assign in_row   = s_axis_tdata[COORD_W-1:0];
    assign in_col   = s_axis_tdata[2*COORD_W-1:COORD_W];
    assign in_pix   = s_axis_tdata[2*COORD_W+PIX_OUT_W-1:2*COORD_W];
    assign accept   = s_axis_tvalid && s_axis_tready;
    assign is_query = s_axis_tuser;
    assign in_oor   = (CFG_W'(in_row) >= dst_rows_reg) || (CFG_W'(in_col) >= dst_cols_reg);
    assign in_store = (32'(in_row) < 32'(MAX_ROWS)) && (32'(in_col) < 32'(MAX_COLS));

    assign eff_rows = (src_rows_reg == '0) ? CFG_W'(1) :
                      (32'(src_rows_reg) > 32'(MAX_ROWS)) ? CFG_W'(MAX_ROWS) : src_rows_reg;
    assign eff_cols = (src_cols_reg == '0) ? CFG_W'(1) :
                      (32'(src_cols_reg) > 32'(MAX_COLS)) ? CFG_W'(MAX_COLS) : src_cols_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            src_rows_reg <= CFG_RESET;
            src_cols_reg <= CFG_RESET;
            dst_rows_reg <= CFG_RESET;
            dst_cols_reg <= CFG_RESET;
        end else if (cfg_we) begin
            unique case (cfg_reg_t'(cfg_addr))
                REG_SRC_ROWS: src_rows_reg <= cfg_wdata;
                REG_SRC_COLS: src_cols_reg <= cfg_wdata;
                REG_DST_ROWS: dst_rows_reg <= cfg_wdata;
                REG_DST_COLS: dst_cols_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (accept && is_query) begin
                    state_next = in_oor ? ST_DONE : ST_MAP;
                end
            end
            ST_MAP: begin
                if (row_done && col_done) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                if (!m_valid_reg || m_axis_tready) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb begin
        s_axis_tready = 1'b0;
        map_start     = 1'b0;
        rd_en         = 1'b0;
        out_load      = 1'b0;
        unique case (state_reg)
            ST_IDLE: begin
                s_axis_tready = 1'b1;
                map_start     = accept && is_query && !in_oor;
            end
            ST_MAP:  rd_en    = row_done && col_done;
            ST_DONE: out_load = !m_valid_reg || m_axis_tready;
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept && is_query) begin
            oor_reg <= in_oor;
        end
    end

    nnis_map u_map_row (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (map_start),
        .coord    (in_row),
        .src_size (eff_rows),
        .dst_size (dst_rows_reg),
        .done     (row_done),
        .src_used (srow)
    );

    nnis_map u_map_col (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (map_start),
        .coord    (in_col),
        .src_size (eff_cols),
        .dst_size (dst_cols_reg),
        .done     (col_done),
        .src_used (scol)
    );

    assign wr_addr = ADDR_W'(ADDR_W'(in_row) * ADDR_W'(MAX_COLS) + ADDR_W'(in_col));
    assign rd_addr = ADDR_W'(ADDR_W'(srow) * ADDR_W'(MAX_COLS) + ADDR_W'(scol));

    nnis_ram #(
        .WIDTH (PIXEL_BITS),
        .DEPTH (DEPTH)
    ) u_frame_store (
        .aclk    (aclk),
        .wr_en   (accept && !is_query && in_store),
        .wr_addr (wr_addr),
        .wr_data (PIXEL_BITS'(in_pix)),
        .rd_en   (rd_en),
        .rd_addr (rd_addr),
        .rd_data (rd_data)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (out_load) begin
            m_valid_reg <= 1'b1;
        end else if (m_axis_tready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_oor_reg <= oor_reg;
            if (oor_reg) begin
                m_pix_reg <= '0;
                m_row_reg <= '0;
                m_col_reg <= '0;
            end else begin
                m_pix_reg <= PIX_OUT_W'(rd_data);
                m_row_reg <= srow[COORD_W-1:0];
                m_col_reg <= scol[COORD_W-1:0];
            end
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = {{M_PAD_W{1'b0}}, m_col_reg, m_row_reg, m_pix_reg};
    assign m_axis_tuser  = m_oor_reg;

endmodule

FILE: test/testbench.sv
// Self-checking testbench for nearest_neighbor_image_scaler_core: loads and queries pixels
// over a stream interface and checks every scaled result against an in-bench prediction.
// Depends on nnis_pkg and the scaler RTL only.
module testbench;
    import nnis_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    localparam logic MODE_LOAD  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;
    localparam int LATENCY_CYCLES = 16;
    localparam int CYCLE_LIMIT    = 500000;

    typedef struct packed {
        logic [PIX_OUT_W-1:0] pixel;
        logic [COORD_W-1:0]   srow;
        logic [COORD_W-1:0]   scol;
        logic                 oor;
    } scaled_pixel_t;

    logic                  aclk = 1'b0;
    logic                  aresetn = 1'b0;
    logic                  cfg_we = 1'b0;
    cfg_reg_t              cfg_addr = REG_SRC_ROWS;
    logic [CFG_W-1:0]      cfg_wdata = '0;
    logic                  s_axis_tvalid = 1'b0;
    logic                  s_axis_tready;
    logic [S_TDATA_W-1:0]  s_axis_tdata = '0;
    logic                  s_axis_tuser = MODE_LOAD;
    logic                  m_axis_tvalid;
    logic                  m_axis_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_axis_tdata;
    logic                  m_axis_tuser;

    logic [7:0]            frame_model [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
    bit                    loaded [0:DEF_MAX_ROWS*DEF_MAX_COLS-1];
    logic [CFG_W-1:0]      src_rows_cfg, src_cols_cfg, dst_rows_cfg, dst_cols_cfg;
    scaled_pixel_t         expected_pixels [$];
    int                    error_count = 0;
    bit                    bursts_enabled = 1'b1;
    int                    stall_left = 0;

    nearest_neighbor_image_scaler_core uut (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cfg_we        (cfg_we),
        .cfg_addr      (cfg_addr),
        .cfg_wdata     (cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    always #1 aclk = ~aclk;

    function automatic int unsigned effective_size(logic [CFG_W-1:0] v, int unsigned maxv);
        if (v == 0) return 1;
        if (v > maxv) return maxv;
        return v;
    endfunction

    function automatic logic [COORD_W-1:0] nearest_source(int unsigned pos, int unsigned src,
                                                          int unsigned dst);
        int unsigned s;
        s = (2 * pos * src + dst) / (2 * dst);
        if (s > src - 1) s = src - 1;
        return s[COORD_W-1:0];
    endfunction

    function automatic scaled_pixel_t scale_lookup(logic [COORD_W-1:0] row,
                                                   logic [COORD_W-1:0] col);
        scaled_pixel_t r;
        r = '0;
        if (row >= dst_rows_cfg || col >= dst_cols_cfg) begin
            r.oor = 1'b1;
            return r;
        end
        r.srow  = nearest_source(row, effective_size(src_rows_cfg, DEF_MAX_ROWS), dst_rows_cfg);
        r.scol  = nearest_source(col, effective_size(src_cols_cfg, DEF_MAX_COLS), dst_cols_cfg);
        r.pixel = frame_model[{r.srow, r.scol}];
        return r;
    endfunction

    function automatic logic [CFG_W-1:0] pick_size();
        case ($urandom_range(0, 9))
            0: return 7'd0;
            1: return 7'd1;
            2: return 7'd64;
            3: return 7'd127;
            default: return CFG_W'($urandom_range(1, 64));
        endcase
    endfunction

    function automatic logic [COORD_W-1:0] pick_coord(logic [CFG_W-1:0] limit);
        if (limit == 0 || limit > 64) return COORD_W'($urandom_range(0, 63));
        return COORD_W'($urandom_range(0, limit - 1));
    endfunction

    // Sends one request and updates the prediction at the edge where it is accepted.
    task automatic send_request(logic mode, logic [COORD_W-1:0] row, logic [COORD_W-1:0] col,
                                logic [7:0] pixel);
        if (bursts_enabled && $urandom_range(0, 4) == 0) begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge aclk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {{(S_TDATA_W-20){1'b0}}, pixel, col, row};
        do @(posedge aclk); while (!s_axis_tready);
        if (mode == MODE_LOAD) begin
            frame_model[{row, col}] = pixel;
            loaded[{row, col}] = 1'b1;
        end else begin
            expected_pixels.push_back(scale_lookup(row, col));
        end
    endtask

    // A query never selects a pixel that has not been loaded, so one is loaded first.
    task automatic request_pixel(logic [COORD_W-1:0] row, logic [COORD_W-1:0] col);
        scaled_pixel_t target;
        target = scale_lookup(row, col);
        if (!target.oor && !loaded[{target.srow, target.scol}])
            send_request(MODE_LOAD, target.srow, target.scol, 8'($urandom_range(0, 255)));
        send_request(MODE_QUERY, row, col, 8'($urandom_range(0, 255)));
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        while (expected_pixels.size() != 0) @(posedge aclk);
        repeat (LATENCY_CYCLES) @(posedge aclk);
    endtask

    task automatic program_sizes(logic [CFG_W-1:0] sr, logic [CFG_W-1:0] sc,
                                 logic [CFG_W-1:0] dr, logic [CFG_W-1:0] dc);
        cfg_reg_t reg_id;
        reg_id = REG_SRC_ROWS;
        repeat (4) begin
            cfg_we   <= 1'b1;
            cfg_addr <= reg_id;
            case (reg_id)
                REG_SRC_ROWS: begin cfg_wdata <= sr; src_rows_cfg = sr; end
                REG_SRC_COLS: begin cfg_wdata <= sc; src_cols_cfg = sc; end
                REG_DST_ROWS: begin cfg_wdata <= dr; dst_rows_cfg = dr; end
                REG_DST_COLS: begin cfg_wdata <= dc; dst_cols_cfg = dc; end
            endcase
            @(posedge aclk);
            reg_id = reg_id.next();
        end
        cfg_we <= 1'b0;
    endtask

    task automatic test_identity_scaling();
        settle();
        program_sizes(7'd64, 7'd64, 7'd64, 7'd64);
        send_request(MODE_LOAD, 6'd0, 6'd0, 8'h00);
        send_request(MODE_LOAD, 6'd0, 6'd63, 8'hff);
        send_request(MODE_LOAD, 6'd63, 6'd0, 8'ha5);
        send_request(MODE_LOAD, 6'd63, 6'd63, 8'h5a);
        request_pixel(6'd0, 6'd0);
        request_pixel(6'd0, 6'd63);
        request_pixel(6'd63, 6'd0);
        request_pixel(6'd63, 6'd63);
    endtask

    task automatic test_size_extremes();
        settle();
        program_sizes(7'd0, 7'd0, 7'd127, 7'd127);
        request_pixel(6'd63, 6'd63);
        request_pixel(6'd0, 6'd0);
        settle();
        program_sizes(7'd127, 7'd127, 7'd1, 7'd1);
        request_pixel(6'd0, 6'd0);
        request_pixel(6'd1, 6'd0);
        request_pixel(6'd0, 6'd1);
        settle();
        program_sizes(7'd64, 7'd64, 7'd0, 7'd0);
        request_pixel(6'd0, 6'd0);
    endtask

    // Three source pixels onto two output pixels puts output 1 exactly halfway; it rounds up.
    task automatic test_rounding_tie();
        settle();
        program_sizes(7'd3, 7'd3, 7'd2, 7'd2);
        request_pixel(6'd1, 6'd1);
        request_pixel(6'd0, 6'd0);
        request_pixel(6'd2, 6'd1);
    endtask

    task automatic test_random_scaling(int phases, int per_phase);
        repeat (phases) begin
            settle();
            program_sizes(pick_size(), pick_size(), pick_size(), pick_size());
            repeat (per_phase) begin
                if ($urandom_range(0, 9) < 4)
                    send_request(MODE_LOAD, 6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)),
                                 8'($urandom_range(0, 255)));
                else if ($urandom_range(0, 3) == 0)
                    request_pixel(6'($urandom_range(0, 63)), 6'($urandom_range(0, 63)));
                else
                    request_pixel(pick_coord(dst_rows_cfg), pick_coord(dst_cols_cfg));
            end
        end
    endtask

    task automatic test_streaming_no_gaps();
        bursts_enabled = 1'b0;
        test_random_scaling(1, 200);
    endtask

    always @(posedge aclk) begin
        scaled_pixel_t want;
        if (aresetn && m_axis_tvalid && m_axis_tready) begin
            if (expected_pixels.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual tdata %h tuser %b",
                         $time, m_axis_tdata, m_axis_tuser);
                error_count++;
            end else begin
                want = expected_pixels.pop_front();
                if (m_axis_tdata[7:0] !== want.pixel) begin
                    $display("%0t: pixel_out expected %0d, actual %0d",
                             $time, want.pixel, m_axis_tdata[7:0]);
                    error_count++;
                end
                if (m_axis_tdata[13:8] !== want.srow) begin
                    $display("%0t: src_row_used expected %0d, actual %0d",
                             $time, want.srow, m_axis_tdata[13:8]);
                    error_count++;
                end
                if (m_axis_tdata[19:14] !== want.scol) begin
                    $display("%0t: src_col_used expected %0d, actual %0d",
                             $time, want.scol, m_axis_tdata[19:14]);
                    error_count++;
                end
                if (m_axis_tuser !== want.oor) begin
                    $display("%0t: out_of_range expected %b, actual %b",
                             $time, want.oor, m_axis_tuser);
                    error_count++;
                end
            end
        end
        if (!bursts_enabled) begin
            stall_left = 0;
            m_axis_tready <= 1'b1;
        end else if (stall_left > 0) begin
            stall_left--;
            m_axis_tready <= 1'b0;
        end else if ($urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 2);
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= 1'b1;
        end
    end

    initial begin
        repeat (CYCLE_LIMIT) @(posedge aclk);
        $display("FAILURE");
        $finish;
    end

    initial begin
        for (int i = 0; i < DEF_MAX_ROWS * DEF_MAX_COLS; i++) begin
            frame_model[i] = '0;
            loaded[i] = 1'b0;
        end
        src_rows_cfg = CFG_RESET;
        src_cols_cfg = CFG_RESET;
        dst_rows_cfg = CFG_RESET;
        dst_cols_cfg = CFG_RESET;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        test_identity_scaling();
        test_size_extremes();
        test_rounding_tie();
        test_random_scaling(5, 210);
        test_streaming_no_gaps();
        settle();

        if (error_count == 0) begin
            $display("SUCCESS");
        end else begin
            $display("FAILURE");
        end
        $finish;
    end

endmodule

FILE: nearest_neighbor_image_scaler_core.f
hdl/nnis_pkg.sv
hdl/nnis_ram.sv
hdl/nnis_map.sv
hdl/nearest_neighbor_image_scaler_core.sv
test/testbench.sv
